// File: sv/i2cmts_pkg.sv
// Shared types and codes for the I2C master transfer sequencer.
// No dependencies; used by i2cmts_step and the top level.
`default_nettype none

package i2cmts_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_START_TX = 2'd0,
        OP_START_RX = 2'd1,
        OP_STATUS   = 2'd2,
        OP_ERROR    = 2'd3
    } op_t;

    // Transfer direction, one-hot
    typedef enum logic [2:0] {
        DIR_READY = 3'b001,
        DIR_TX    = 3'b010,
        DIR_RX    = 3'b100
    } dir_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] dev_address;
        logic [7:0] byte_count;
        logic       flag_sb;
        logic       flag_addr;
        logic       flag_btf;
        logic       flag_txe;
        logic       flag_rxne;
        logic [7:0] data_in;
    } item_t;

    typedef struct packed {
        dir_t       direction;
        logic [6:0] target_address;
        logic [7:0] bytes_left;
        logic [7:0] rx_total;
        logic       event_irq_on;
        logic       buffer_irq_on;
        logic       ack_enable;
    } seq_state_t;

    typedef struct packed {
        logic       dr_write;
        logic [7:0] dr_value;
        logic       start_req;
        logic       stop_req;
        logic       ack_on;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       start_accepted;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage

`default_nettype wire

// File: sv/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: input register, sequencer
// state, result register. Uses i2cmts_pkg and i2cmts_step.
`default_nettype none

// Interrupt-style I2C master sequencer. Each input word is a start-transmit,
// start-receive, status-event or error item (kind on s_tuser); each produces
// exactly one result word on m_*. A start is taken only while idle; status
// flags are handled in the order SB, ADDR, BTF, TXE, RXNE, and an error item
// aborts the transfer without a STOP. Timing: a word is held in the input
// register and its result is written to the result register as it advances;
// throughput is one word per cycle unless m_tready stalls. The single
// sequencer state register is updated as the word moves into the result
// register, so consecutive words see each other's effect in order.
// s_tready stays high while the input register is empty or draining; a
// stalled m_tready backs up through one input word before s_tready drops.
module i2c_master_transfer_sequencer (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    // [6:0] dev_address, [14:7] byte_count, [15] flag_sb, [16] flag_addr,
    // [17] flag_btf, [18] flag_txe, [19] flag_rxne, [27:20] data_in, [31:28] zero
    input  wire [31:0] s_tdata,
    // [1:0] op
    input  wire [1:0]  s_tuser,
    output logic       m_tvalid,
    input  wire        m_tready,
    // [0] dr_write, [8:1] dr_value, [9] start_req, [10] stop_req, [11] ack_on,
    // [12] tx_taken, [13] rx_valid, [21:14] rx_byte, [29:22] rx_index,
    // [30] start_accepted, [31] busy_res, [32] done_res, [39:33] zero
    output logic [39:0] m_tdata
);

    i2cmts_pkg::item_t      in_reg;
    logic                   in_valid_reg;
    i2cmts_pkg::seq_state_t state_reg;
    i2cmts_pkg::seq_state_t state_next;
    i2cmts_pkg::result_t    res_next;
    i2cmts_pkg::result_t    res_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   s_take;

    // word moves from input register to result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg.op          <= i2cmts_pkg::op_t'(s_tuser);
            in_reg.dev_address <= s_tdata[6:0];
            in_reg.byte_count  <= s_tdata[14:7];
            in_reg.flag_sb     <= s_tdata[15];
            in_reg.flag_addr   <= s_tdata[16];
            in_reg.flag_btf    <= s_tdata[17];
            in_reg.flag_txe    <= s_tdata[18];
            in_reg.flag_rxne   <= s_tdata[19];
            in_reg.data_in     <= s_tdata[27:20];
        end
    end

    i2cmts_step u_step (
        .item (in_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.direction      <= i2cmts_pkg::DIR_READY;
            state_reg.target_address <= '0;
            state_reg.bytes_left     <= '0;
            state_reg.rx_total       <= '0;
            state_reg.event_irq_on   <= 1'b0;
            state_reg.buffer_irq_on  <= 1'b0;
            state_reg.ack_enable     <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       res_reg.done_res,
                       res_reg.busy_res,
                       res_reg.start_accepted,
                       res_reg.rx_index,
                       res_reg.rx_byte,
                       res_reg.rx_valid,
                       res_reg.tx_taken,
                       res_reg.ack_on,
                       res_reg.stop_req,
                       res_reg.start_req,
                       res_reg.dr_value,
                       res_reg.dr_write};

endmodule

`default_nettype wire

// File: sv/i2cmts_step.sv
// Next-state and result logic for one word of the transfer sequencer.
// Purely combinational; types from i2cmts_pkg.
`default_nettype none

module i2cmts_step (
    input  wire i2cmts_pkg::item_t      item,
    input  wire i2cmts_pkg::seq_state_t cur,
    output i2cmts_pkg::seq_state_t      nxt,
    output i2cmts_pkg::result_t         res
);

    logic idle;
    logic evt;
    logic buf_on;

    assign idle   = (cur.direction != i2cmts_pkg::DIR_TX) &&
                    (cur.direction != i2cmts_pkg::DIR_RX);
    assign evt    = cur.event_irq_on;
    assign buf_on = cur.buffer_irq_on;

    always_comb begin
        nxt = cur;
        res = '0;
        unique case (item.op)
            i2cmts_pkg::OP_START_TX, i2cmts_pkg::OP_START_RX: begin
                if (idle) begin
                    nxt.target_address = item.dev_address;
                    nxt.bytes_left     = item.byte_count;
                    if (item.op == i2cmts_pkg::OP_START_RX) begin
                        nxt.rx_total   = item.byte_count;
                        nxt.direction  = i2cmts_pkg::DIR_RX;
                        nxt.ack_enable = 1'b1;
                    end else begin
                        nxt.direction  = i2cmts_pkg::DIR_TX;
                    end
                    nxt.event_irq_on   = 1'b1;
                    nxt.buffer_irq_on  = 1'b1;
                    res.start_req      = 1'b1;
                    res.start_accepted = 1'b1;
                end
            end
            i2cmts_pkg::OP_STATUS: begin
                // SB: address plus R/W bit
                if (evt && item.flag_sb) begin
                    res.dr_write = 1'b1;
                    res.dr_value = {cur.target_address,
                                    cur.direction == i2cmts_pkg::DIR_RX};
                end
                // ADDR: single-byte read needs NACK up front
                if (evt && item.flag_addr && nxt.direction == i2cmts_pkg::DIR_RX &&
                    nxt.bytes_left == 8'd1) begin
                    nxt.ack_enable = 1'b0;
                end
                // BTF with empty TX register and nothing left closes a write
                if (evt && item.flag_btf && nxt.direction == i2cmts_pkg::DIR_TX &&
                    item.flag_txe && nxt.bytes_left == 8'd0) begin
                    res.stop_req      = 1'b1;
                    res.done_res      = 1'b1;
                    nxt.event_irq_on  = 1'b0;
                    nxt.buffer_irq_on = 1'b0;
                    nxt.direction     = i2cmts_pkg::DIR_READY;
                    nxt.ack_enable    = 1'b1;
                end
                // TXE: next data byte, address write wins
                if (evt && buf_on && item.flag_txe &&
                    nxt.direction == i2cmts_pkg::DIR_TX && !res.dr_write &&
                    nxt.bytes_left != 8'd0) begin
                    res.dr_write   = 1'b1;
                    res.dr_value   = item.data_in;
                    res.tx_taken   = 1'b1;
                    nxt.bytes_left = nxt.bytes_left - 8'd1;
                end
                // RXNE: deliver byte, NACK at two left, STOP on last
                if (evt && buf_on && item.flag_rxne &&
                    nxt.direction == i2cmts_pkg::DIR_RX) begin
                    if (cur.rx_total == 8'd1) begin
                        res.stop_req      = 1'b1;
                        res.rx_valid      = 1'b1;
                        res.rx_byte       = item.data_in;
                        res.done_res      = 1'b1;
                        nxt.bytes_left    = 8'd0;
                        nxt.event_irq_on  = 1'b0;
                        nxt.buffer_irq_on = 1'b0;
                        nxt.direction     = i2cmts_pkg::DIR_READY;
                        nxt.ack_enable    = 1'b1;
                    end else if (cur.rx_total > 8'd1 && nxt.bytes_left != 8'd0) begin
                        if (nxt.bytes_left == 8'd2) begin
                            nxt.ack_enable = 1'b0;
                        end
                        res.rx_valid   = 1'b1;
                        res.rx_byte    = item.data_in;
                        res.rx_index   = cur.rx_total - nxt.bytes_left;
                        nxt.bytes_left = nxt.bytes_left - 8'd1;
                        if (nxt.bytes_left == 8'd0) begin
                            res.stop_req      = 1'b1;
                            res.done_res      = 1'b1;
                            nxt.event_irq_on  = 1'b0;
                            nxt.buffer_irq_on = 1'b0;
                            nxt.direction     = i2cmts_pkg::DIR_READY;
                            nxt.ack_enable    = 1'b1;
                        end
                    end
                end
            end
            i2cmts_pkg::OP_ERROR: begin
                // abort: no STOP, ACK back on
                if (evt) begin
                    res.done_res      = 1'b1;
                    nxt.event_irq_on  = 1'b0;
                    nxt.buffer_irq_on = 1'b0;
                    nxt.direction     = i2cmts_pkg::DIR_READY;
                    nxt.ack_enable    = 1'b1;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        res.ack_on   = nxt.ack_enable;
        res.busy_res = (nxt.direction == i2cmts_pkg::DIR_TX) ||
                       (nxt.direction == i2cmts_pkg::DIR_RX);
    end

endmodule

`default_nettype wire
